FILE: rtl/mlfq_pkg.sv
`timescale 1ns / 1ps
package mlfq_pkg;

  localparam int THREAD_SLOTS_DEF  = 32;
  localparam int FRACTION_BITS_DEF = 14;
  localparam int PRI_MIN = 0;
  localparam int PRI_MAX = 63;

  localparam int REQ_W   = 3;
  localparam int SLOT_W  = 5;
  localparam int READY_W = 6;
  localparam int NICE_W  = 6;
  localparam int PRI_W   = 6;
  localparam int FP_W    = 32;
  localparam int LOADX_W = 12;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 3'd0,
    REQ_REFRESH = 3'd1,
    REQ_SECOND  = 3'd2,
    REQ_NICE    = 3'd3,
    REQ_QUERY   = 3'd4,
    REQ_CREATE  = 3'd5,
    REQ_REMOVE  = 3'd6
  } req_t;

  // saturate a 64-bit signed value to the signed 32-bit range
  function automatic logic signed [FP_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [FP_W-1:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[FP_W-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/mlfq_div.sv
`timescale 1ns / 1ps
// Restoring divider for nonnegative operands, one quotient bit a cycle.
module mlfq_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  import mlfq_pkg::*;

  logic [63:0] rem_r, rem_nxt, q_r, q_nxt, d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt, done_r;
  logic [64:0] trial;

  // shift one bit in, try subtract
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    trial   = {rem_r, q_r[63]};
    if (run_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = 64'(trial - {1'b0, d_r});
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = 7'(cnt_r - 7'd1);
      if (cnt_r == 7'd1) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 7'd64;
    end else begin
      run_r  <= run_nxt;
      done_r <= run_r && (cnt_r == 7'd1);
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      q_r   <= num;
      d_r   <= den;
    end else begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

FILE: rtl/mlfq_priority_engine.sv
`timescale 1ns / 1ps
// Timing depends on the request: tick and set nice take longer on a live slot
// than on a dead one; refresh and the per-second update walk every slot,
// spending longer on live slots than on empty ones, and the per-second update
// also runs the coefficient divide before its walk.
// One word at a time: busy stays high until the strobe; results cannot stall.
// Reset (rst_n low, synchronous) clears the sequencer, busy, strobe, valid bits and load average, not slot memory.
module mlfq_priority_engine #(
  parameter int THREAD_SLOTS  = mlfq_pkg::THREAD_SLOTS_DEF,
  parameter int FRACTION_BITS = mlfq_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mlfq_pkg::REQ_W-1:0]        in_req_type,
  input  logic [mlfq_pkg::SLOT_W-1:0]       in_thread_slot,
  input  logic                              in_running_is_idle,
  input  logic [mlfq_pkg::READY_W-1:0]      in_ready_count,
  input  logic signed [mlfq_pkg::NICE_W-1:0] in_nice_value,
  output logic                              out_strobe,
  output logic [mlfq_pkg::PRI_W-1:0]        out_priority_res,
  output logic signed [mlfq_pkg::FP_W-1:0]  out_cpu_usage_x100,
  output logic [mlfq_pkg::LOADX_W-1:0]      out_load_avg_x100,
  output logic                              out_slot_valid
);
  import mlfq_pkg::*;

  localparam int IDX_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int CNT_W = $clog2(THREAD_SLOTS + 1);
  localparam longint FONE = longint'(1) << FRACTION_BITS;
  localparam longint C1 = (59 * FONE) / 60;
  localparam longint C2 = FONE / 60;
  localparam longint HALF = FONE / 2;
  localparam longint PRI_BASE = longint'(PRI_MAX) * FONE;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD1, S_LOAD2, S_DIVGO, S_DIVW, S_RD, S_WAIT, S_MUL, S_ACC,
    S_PRI, S_WB, S_ORD, S_OWAIT, S_OMUL, S_OUT
  } st_t;

  // slot memory: {cpu usage, nice, priority}
  localparam int ENT_W = FP_W + NICE_W + PRI_W;
  logic [ENT_W-1:0] mem [THREAD_SLOTS];
  logic [ENT_W-1:0] rd_r;
  logic [IDX_W-1:0] raddr, waddr;
  logic             we;
  logic [ENT_W-1:0] wdata;
  logic [THREAD_SLOTS-1:0] valid_r;

  st_t  st_r;
  req_t req_r;
  logic [SLOT_W-1:0] slot_r;
  logic idle_r;
  logic [READY_W-1:0] ready_r;
  logic signed [NICE_W-1:0] nv_r;
  logic [CNT_W-1:0] idx_r;
  logic signed [FP_W-1:0] load_r, rc_r;
  logic signed [63:0] prod_r, acc_r;
  logic [FRACTION_BITS:0] coef_r;
  logic signed [NICE_W-1:0] ni_r;
  logic [PRI_W-1:0] pr_r;
  logic busy_r, strobe_r;
  logic div_go;
  logic div_done;
  logic [63:0] div_q;

  logic exists;
  assign exists = (32'(slot_r) < THREAD_SLOTS);

  mlfq_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go),
    .num(64'(2 * longint'(load_r) * FONE)),
    .den(64'(2 * longint'(load_r) + FONE)),
    .done(div_done), .quo(div_q)
  );
  assign div_go = (st_r == S_DIVGO) && (2 * longint'(load_r) + FONE > 0);

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  // round (v +- F/2)/F truncating toward zero
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [63:0] q;
    t = (v >= 0) ? v + HALF : v - HALF;
    q = t >>> FRACTION_BITS;
    if (t < 0 && (t & (FONE - 1)) != 0) q = q + 1;
    return q;
  endfunction

  // signed truncating divide by F
  function automatic logic signed [63:0] divf(input logic signed [63:0] v);
    logic signed [63:0] q;
    q = v >>> FRACTION_BITS;
    if (v < 0 && (v & (FONE - 1)) != 0) q = q + 1;
    return q;
  endfunction

  logic signed [63:0] pv;
  logic signed [63:0] pr_round;
  logic [PRI_W-1:0] pri_calc;
  logic signed [63:0] rc_div4;
  always_comb begin
    rc_div4 = (rc_r < 0) ? -((-longint'(rc_r)) >>> 2) : (longint'(rc_r) >>> 2);
    pv = PRI_BASE - rc_div4 - longint'(ni_r) * 2 * FONE;
    pr_round = rnd(pv);
    if (pr_round > PRI_MAX) pri_calc = PRI_W'(PRI_MAX);
    else if (pr_round < PRI_MIN) pri_calc = PRI_W'(PRI_MIN);
    else pri_calc = pr_round[PRI_W-1:0];
  end

  logic [IDX_W-1:0] sidx;
  assign sidx = IDX_W'(slot_r);
  logic live;
  assign live = exists && valid_r[sidx];

  always_comb begin
    raddr = idx_r[IDX_W-1:0];
    if (st_r == S_ORD || st_r == S_RD && (req_r == REQ_TICK || req_r == REQ_NICE))
      raddr = sidx;
    waddr = idx_r[IDX_W-1:0];
    if (req_r != REQ_REFRESH && req_r != REQ_SECOND) waddr = sidx;
    we    = (st_r == S_WB);
    wdata = {rc_r, ni_r, pri_calc};
    // a tick keeps the stored priority
    if (req_r == REQ_TICK) wdata = {rc_r, ni_r, pr_r};
    if (req_r == REQ_CREATE) wdata = '0;
  end

  logic [CNT_W-1:0] last;
  assign last = CNT_W'(THREAD_SLOTS - 1);
  logic walk;
  assign walk = (req_r == REQ_REFRESH) || (req_r == REQ_SECOND);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
      valid_r  <= '0;
      load_r   <= '0;
    end else begin
      strobe_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (start) begin
          req_r   <= req_t'(in_req_type);
          slot_r  <= in_thread_slot;
          idle_r  <= in_running_is_idle;
          ready_r <= in_ready_count;
          nv_r    <= in_nice_value;
          idx_r   <= '0;
          busy_r  <= 1'b1;
          st_r    <= (in_req_type == REQ_SECOND) ? S_LOAD1 : S_RD;
        end
        S_LOAD1: begin
          prod_r <= C1 * longint'(load_r);
          st_r   <= S_LOAD2;
        end
        S_LOAD2: begin
          load_r <= sat32(divf(prod_r) + C2 * longint'(ready_r));
          st_r   <= S_DIVGO;
        end
        S_DIVGO: begin
          coef_r <= '0;
          st_r   <= div_go ? S_DIVW : S_RD;
        end
        S_DIVW: if (div_done) begin
          coef_r <= div_q[FRACTION_BITS:0];
          st_r   <= S_RD;
        end
        S_RD: begin
          priority if (walk && !valid_r[idx_r[IDX_W-1:0]]) begin
            if (idx_r == last) st_r <= S_ORD;
            else idx_r <= idx_r + 1'b1;
          end else if (req_r == REQ_CREATE) begin
            if (exists) begin
              valid_r[sidx] <= 1'b1;
              st_r <= S_WB;
            end else st_r <= S_ORD;
          end else if (req_r == REQ_REMOVE) begin
            if (exists) valid_r[sidx] <= 1'b0;
            st_r <= S_ORD;
          end else if (walk || (req_r == REQ_TICK && !idle_r && live)
                       || (req_r == REQ_NICE && live)) begin
            st_r <= S_WAIT;
          end else st_r <= S_ORD;
        end
        S_WAIT: begin
          rc_r <= rd_r[ENT_W-1 -: FP_W];
          ni_r <= (req_r == REQ_NICE) ? nv_r : rd_r[PRI_W +: NICE_W];
          pr_r <= rd_r[PRI_W-1:0];
          st_r <= (req_r == REQ_SECOND) ? S_MUL : S_ACC;
        end
        S_MUL: begin
          prod_r <= longint'({1'b0, coef_r}) * longint'(rc_r);
          st_r   <= S_ACC;
        end
        S_ACC: begin
          if (req_r == REQ_SECOND)
            rc_r <= sat32(divf(prod_r) + longint'(ni_r) * FONE);
          else if (req_r == REQ_TICK)
            rc_r <= sat32(longint'(rc_r) + FONE);
          st_r <= S_PRI;
        end
        S_PRI: st_r <= S_WB;
        S_WB: begin
          if (walk && idx_r != last) begin
            idx_r <= idx_r + 1'b1;
            st_r  <= S_RD;
          end else st_r <= S_ORD;
        end
        S_ORD:   st_r <= S_OWAIT;
        S_OWAIT: begin
          rc_r <= rd_r[ENT_W-1 -: FP_W];
          pr_r <= rd_r[PRI_W-1:0];
          st_r <= S_OMUL;
        end
        S_OMUL: begin
          prod_r <= longint'(rc_r) * 100;
          acc_r  <= longint'(load_r) * 100;
          st_r   <= S_OUT;
        end
        S_OUT: begin
          strobe_r <= 1'b1;
          busy_r   <= 1'b0;
          st_r     <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // result word from the staged products
  logic signed [63:0] lx;
  always_comb begin
    lx = rnd(acc_r);
    if (lx < 0) lx = 0;
    if (lx > 4095) lx = 4095;
  end

  logic [PRI_W-1:0] opri_r;
  logic signed [FP_W-1:0] orc_r;
  logic [LOADX_W-1:0] old_r;
  logic olive_r;
  always_ff @(posedge clk) begin
    if (st_r == S_OUT) begin
      olive_r <= live;
      opri_r  <= live ? pr_r : '0;
      orc_r   <= live ? sat32(rnd(prod_r)) : '0;
      old_r   <= lx[LOADX_W-1:0];
    end
  end

  assign busy                = busy_r;
  assign out_strobe          = strobe_r;
  assign out_priority_res    = opri_r;
  assign out_cpu_usage_x100  = orc_r;
  assign out_load_avg_x100   = old_r;
  assign out_slot_valid      = olive_r;

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe repeated");
  a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("busy at strobe");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted without busy");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import mlfq_pkg::*;

  localparam int SLOTS     = THREAD_SLOTS_DEF;
  localparam int FBITS     = FRACTION_BITS_DEF;
  localparam longint FONE  = 64'sd1 << FBITS;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [PRI_W-1:0]          pri;
    logic signed [FP_W-1:0]    rcpu;
    logic [LOADX_W-1:0]        load;
    logic                      live;
  } slot_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [SLOT_W-1:0] in_thread_slot = '0;
  logic in_running_is_idle = 1'b0;
  logic [READY_W-1:0] in_ready_count = '0;
  logic signed [NICE_W-1:0] in_nice_value = '0;
  logic out_strobe;
  logic [PRI_W-1:0] out_priority_res;
  logic signed [FP_W-1:0] out_cpu_usage_x100;
  logic [LOADX_W-1:0] out_load_avg_x100;
  logic out_slot_valid;

  mlfq_priority_engine dut (.*);

  // scheduler shadow state
  int          cpu_q[SLOTS];
  int          nice_q[SLOTS];
  int          pri_q[SLOTS];
  bit          live_q[SLOTS];
  int          load_fp;
  slot_word_t  pending_words[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          no_gaps = 1'b0;

  initial forever #4 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_near(longint v);
    return v >= 0 ? (v + FONE / 2) / FONE : (v - FONE / 2) / FONE;
  endfunction

  function automatic void refresh_pri(int s);
    longint p;
    p = round_near(63 * FONE - longint'(cpu_q[s]) / 4 - longint'(nice_q[s]) * 2 * FONE);
    if (p > PRI_MAX) p = PRI_MAX;
    if (p < PRI_MIN) p = PRI_MIN;
    pri_q[s] = int'(p);
  endfunction

  // apply one request to the shadow state and return the expected word
  function automatic slot_word_t schedule_step(req_t op, int s, bit idle, int ready, int nv);
    slot_word_t w;
    longint twice, coef, lx;
    case (op)
      REQ_TICK: if (!idle && live_q[s]) cpu_q[s] = int'(clamp32(longint'(cpu_q[s]) + FONE));
      REQ_REFRESH: for (int i = 0; i < SLOTS; i++) if (live_q[i]) refresh_pri(i);
      REQ_SECOND: begin
        load_fp = int'(clamp32(((59 * FONE) / 60 * longint'(load_fp)) / FONE
                               + (FONE / 60) * ready));
        twice = 2 * longint'(load_fp);
        coef = (twice + FONE > 0) ? (twice * FONE) / (twice + FONE) : 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!live_q[i]) continue;
          cpu_q[i] = int'(clamp32((coef * longint'(cpu_q[i])) / FONE
                                  + longint'(nice_q[i]) * FONE));
          refresh_pri(i);
        end
      end
      REQ_NICE: if (live_q[s]) begin
        nice_q[s] = nv;
        refresh_pri(s);
      end
      REQ_CREATE: begin
        live_q[s] = 1'b1;
        nice_q[s] = 0;
        cpu_q[s] = 0;
        pri_q[s] = 0;
      end
      REQ_REMOVE: live_q[s] = 1'b0;
      default: ;
    endcase
    w.live = live_q[s];
    w.pri = live_q[s] ? pri_q[s][PRI_W-1:0] : '0;
    w.rcpu = live_q[s] ? FP_W'(clamp32(round_near(longint'(cpu_q[s]) * 100))) : '0;
    lx = round_near(longint'(load_fp) * 100);
    if (lx < 0) lx = 0;
    if (lx > 4095) lx = 4095;
    w.load = lx[LOADX_W-1:0];
    return w;
  endfunction

  // send one word and wait for acceptance
  task automatic send_word(logic [2:0] op, int s, bit idle, int ready, int nv);
    if (!no_gaps) while ($urandom_range(99) < 9) @(posedge clk);
    in_req_type <= op;
    in_thread_slot <= s[SLOT_W-1:0];
    in_running_is_idle <= idle;
    in_ready_count <= ready[READY_W-1:0];
    in_nice_value <= nv[NICE_W-1:0];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_words.push_back(schedule_step(req_t'(op), s, idle, ready, nv));
    start <= 1'b0;
    @(posedge clk);
  endtask

  // check each strobed word against the oldest expectation
  always @(posedge clk) begin
    slot_word_t got, want;
    if (rst_n && out_strobe) begin
      got = '{out_priority_res, out_cpu_usage_x100, out_load_avg_x100, out_slot_valid};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("mlfq_priority_engine verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(REQ_QUERY, 0, 0, 0, 0);
    send_word(REQ_TICK, 3, 0, 0, 0);            // tick on dead slot
    send_word(REQ_NICE, 3, 0, 0, 5);            // nice on dead slot
    send_word(REQ_CREATE, 0, 0, 0, 0);
    send_word(REQ_CREATE, 31, 0, 0, 0);
    send_word(REQ_TICK, 0, 0, 0, 0);
    send_word(REQ_TICK, 0, 1, 0, 0);            // idle blocks the tick
    send_word(REQ_NICE, 0, 0, 0, -32);
    send_word(REQ_NICE, 31, 0, 0, 31);
    send_word(REQ_REFRESH, 0, 0, 0, 0);
    send_word(REQ_SECOND, 0, 0, 63, 0);
    send_word(REQ_SECOND, 31, 0, 32, 0);
    send_word(REQ_SECOND, 0, 0, 0, 0);
    send_word(REQ_CREATE, 0, 0, 0, 0);          // reinitialize live slot
    send_word(REQ_REMOVE, 31, 0, 0, 0);
    send_word(REQ_QUERY, 31, 0, 0, 0);
    send_word(3'd7, 0, 1, 42, -1);              // unused code acts as query
    send_word(REQ_NICE, 0, 0, 0, 20);
    send_word(REQ_NICE, 0, 0, 0, -20);
  endtask

  task automatic test_random(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      no_gaps = (n >= count / 3) && (n < count / 2);
      roll = $urandom_range(99);
      if (roll < 35)
        send_word(REQ_TICK, $urandom_range(7), $urandom_range(9) == 0, $urandom_range(63),
                  $urandom_range(63) - 32);
      else if (roll < 45)
        send_word(REQ_REFRESH, $urandom_range(31), $urandom_range(1), $urandom_range(63), 0);
      else if (roll < 52)
        send_word(REQ_SECOND, $urandom_range(31), $urandom_range(1),
                  $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(32), 0);
      else if (roll < 64)
        send_word(REQ_NICE, $urandom_range(7), $urandom_range(1), 0, $urandom_range(63) - 32);
      else if (roll < 76)
        send_word(REQ_QUERY, $urandom_range(31), $urandom_range(1), $urandom_range(63), 0);
      else if (roll < 88)
        send_word(REQ_CREATE, $urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(7),
                  0, 0, 0);
      else if (roll < 95)
        send_word(REQ_REMOVE, $urandom_range(31), 0, 0, 0);
      else
        send_word(3'd7, $urandom_range(31), $urandom_range(1), $urandom_range(63),
                  $urandom_range(63) - 32);
    end
    no_gaps = 1'b0;
  endtask

  // heavy load on a high-nice thread drives cpu usage and the load average up
  task automatic test_saturation();
    send_word(REQ_CREATE, 5, 0, 0, 0);
    send_word(REQ_NICE, 5, 0, 0, 31);
    for (int n = 0; n < 40; n++) send_word(REQ_SECOND, 5, 0, 63, 0);
    send_word(REQ_REFRESH, 5, 0, 0, 0);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cpu_q[i] = 0;
      nice_q[i] = 0;
      pri_q[i] = 0;
      live_q[i] = 1'b0;
    end
    load_fp = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random(600);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0)
      $display("mlfq_priority_engine verification clean");
    else
      $display("mlfq_priority_engine verification failed");
    $finish;
  end
endmodule
